// ----- rtl/core/cau_pkg.sv -----
// ----------------------------------------------------------------------------
// cau_pkg
// Shared constants, action codes and pipeline word types of the complex
// arithmetic unit.
// ----------------------------------------------------------------------------
package cau_pkg;

  localparam int unsigned W     = 32;
  localparam int unsigned F     = 16;
  localparam int unsigned PW    = 2 * W;
  localparam int unsigned SH    = W - F;
  localparam int unsigned NCELL = W;

  localparam logic [3:0] ACT_ADD   = 4'd0;
  localparam logic [3:0] ACT_SUB   = 4'd1;
  localparam logic [3:0] ACT_MUL   = 4'd2;
  localparam logic [3:0] ACT_DIV   = 4'd3;
  localparam logic [3:0] ACT_NEG   = 4'd4;
  localparam logic [3:0] ACT_CONJ  = 4'd5;
  localparam logic [3:0] ACT_ABS2  = 4'd6;
  localparam logic [3:0] ACT_RECIP = 4'd7;
  localparam logic [3:0] ACT_EQ    = 4'd8;

  typedef struct packed {
    logic          neg;
    logic          ovf;
    logic [PW-1:0] rem;
    logic [W-1:0]  qn;
    logic [W:0]    pre;
  } cau_lane_t;

  typedef struct packed {
    logic          is_div;
    logic          eq;
    logic          dz;
    logic [PW-1:0] den;
    cau_lane_t     re;
    cau_lane_t     im;
  } cau_word_t;

endpackage

// ----- rtl/core/complex_arithmetic_unit.sv -----
// The result strobe valid_o follows start through the front stages, the divider cells and the tail stages.
// Throughput: one word per cycle; busy stays low, the receiver cannot stall.
// The divider row yields one quotient bit per cell, 32 cells.
// Reset clears only the valid bits of the stages; no results are pending.
// ----------------------------------------------------------------------------
// complex_arithmetic_unit
// Pipelined signed Q16.16 complex ALU: add, sub, mul, div, neg, conj, abs2,
// reciprocal and equality, with saturation and divide-by-zero flags.
// ----------------------------------------------------------------------------
module complex_arithmetic_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic [3:0]                   action_i,
  input  logic                         swap_operands_i,
  input  logic signed [cau_pkg::W-1:0] a_re_i,
  input  logic signed [cau_pkg::W-1:0] a_im_i,
  input  logic signed [cau_pkg::W-1:0] b_re_i,
  input  logic signed [cau_pkg::W-1:0] b_im_i,
  output logic                         valid_o,
  output logic signed [cau_pkg::W-1:0] res_re_o,
  output logic signed [cau_pkg::W-1:0] res_im_o,
  output logic                         is_equal_o,
  output logic                         div_by_zero_o,
  output logic                         saturated_o
);

  localparam int unsigned NCELL = cau_pkg::NCELL;

  logic               vchain [NCELL+1];
  cau_pkg::cau_word_t wchain [NCELL+1];

  assign busy = 1'b0;

  cau_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .valid_i         (start),
    .action_i        (action_i),
    .swap_operands_i (swap_operands_i),
    .a_re_i          (a_re_i),
    .a_im_i          (a_im_i),
    .b_re_i          (b_re_i),
    .b_im_i          (b_im_i),
    .valid_o         (vchain[0]),
    .word_o          (wchain[0])
  );

  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    cau_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (vchain[i]),
      .word_i  (wchain[i]),
      .valid_o (vchain[i+1]),
      .word_o  (wchain[i+1])
    );
  end

  cau_tail u_tail (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (vchain[NCELL]),
    .word_i        (wchain[NCELL]),
    .valid_o       (valid_o),
    .res_re_o      (res_re_o),
    .res_im_o      (res_im_o),
    .is_equal_o    (is_equal_o),
    .div_by_zero_o (div_by_zero_o),
    .saturated_o   (saturated_o)
  );

endmodule

// ----- rtl/core/cau_front.sv -----
// ----------------------------------------------------------------------------
// cau_front
// Operand swap, products, sums, magnitudes and divider setup of the complex
// arithmetic unit, five register stages.
// ----------------------------------------------------------------------------
module cau_front (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     valid_i,
  input  logic [3:0]               action_i,
  input  logic                     swap_operands_i,
  input  logic signed [cau_pkg::W-1:0] a_re_i,
  input  logic signed [cau_pkg::W-1:0] a_im_i,
  input  logic signed [cau_pkg::W-1:0] b_re_i,
  input  logic signed [cau_pkg::W-1:0] b_im_i,
  output logic                     valid_o,
  output cau_pkg::cau_word_t       word_o
);

  localparam int unsigned W  = cau_pkg::W;
  localparam int unsigned F  = cau_pkg::F;
  localparam int unsigned PW = cau_pkg::PW;
  localparam int unsigned SH = cau_pkg::SH;
  localparam logic [PW:0] HALF = (PW+1)'(1) << (F - 1);

  logic                s1_valid_q;
  logic [3:0]          s1_act_q;
  logic signed [W-1:0] s1_ar_q, s1_ai_q, s1_br_q, s1_bi_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_act_q <= action_i;
    s1_ar_q  <= swap_operands_i ? b_re_i : a_re_i;
    s1_ai_q  <= swap_operands_i ? b_im_i : a_im_i;
    s1_br_q  <= swap_operands_i ? a_re_i : b_re_i;
    s1_bi_q  <= swap_operands_i ? a_im_i : b_im_i;
  end

  logic                 s2_valid_q;
  logic [3:0]           s2_act_q;
  logic signed [PW-1:0] s2_prr_q, s2_pii_q, s2_pri_q, s2_pir_q;
  logic [PW-1:0]        s2_sqx_q, s2_sqy_q;
  logic signed [W:0]    s2_sre_q, s2_sim_q;
  logic signed [W-1:0]  s2_ar_q, s2_ai_q;
  logic                 s2_az_q, s2_bz_q, s2_eq_q;
  logic signed [W-1:0]  sq_x, sq_y;
  logic signed [PW-1:0] sqx_s, sqy_s;
  logic signed [W:0]    s_re_d, s_im_d;

  always_comb begin
    sq_x = s1_br_q;
    sq_y = s1_bi_q;
    if (s1_act_q == cau_pkg::ACT_ABS2 || s1_act_q == cau_pkg::ACT_RECIP) begin
      sq_x = s1_ar_q;
      sq_y = s1_ai_q;
    end
    sqx_s = PW'(sq_x) * PW'(sq_x);
    sqy_s = PW'(sq_y) * PW'(sq_y);
  end

  always_comb begin
    s_re_d = '0;
    s_im_d = '0;
    case (s1_act_q)
      cau_pkg::ACT_ADD: begin
        s_re_d = (W+1)'(s1_ar_q) + (W+1)'(s1_br_q);
        s_im_d = (W+1)'(s1_ai_q) + (W+1)'(s1_bi_q);
      end
      cau_pkg::ACT_SUB: begin
        s_re_d = (W+1)'(s1_ar_q) - (W+1)'(s1_br_q);
        s_im_d = (W+1)'(s1_ai_q) - (W+1)'(s1_bi_q);
      end
      cau_pkg::ACT_NEG: begin
        s_re_d = -(W+1)'(s1_ar_q);
        s_im_d = -(W+1)'(s1_ai_q);
      end
      cau_pkg::ACT_CONJ: begin
        s_re_d = (W+1)'(s1_ar_q);
        s_im_d = -(W+1)'(s1_ai_q);
      end
      default: begin
        s_re_d = '0;
        s_im_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s2_act_q <= s1_act_q;
    s2_prr_q <= PW'(s1_ar_q) * PW'(s1_br_q);
    s2_pii_q <= PW'(s1_ai_q) * PW'(s1_bi_q);
    s2_pri_q <= PW'(s1_ar_q) * PW'(s1_bi_q);
    s2_pir_q <= PW'(s1_ai_q) * PW'(s1_br_q);
    s2_sqx_q <= unsigned'(sqx_s);
    s2_sqy_q <= unsigned'(sqy_s);
    s2_sre_q <= s_re_d;
    s2_sim_q <= s_im_d;
    s2_ar_q  <= s1_ar_q;
    s2_ai_q  <= s1_ai_q;
    s2_az_q  <= (s1_ar_q == '0) && (s1_ai_q == '0);
    s2_bz_q  <= (s1_br_q == '0) && (s1_bi_q == '0);
    s2_eq_q  <= (s1_ar_q == s1_br_q) && (s1_ai_q == s1_bi_q);
  end

  logic               s3_valid_q;
  logic signed [PW:0] s3_vre_q, s3_vim_q;
  logic [PW-1:0]      s3_den_q;
  logic               s3_rnd_q, s3_div_q, s3_eq_q, s3_dz_q;
  logic [PW-1:0]      den_d;
  logic signed [PW:0] v_re_d, v_im_d;
  logic               rnd_d, div_d, eq_d, dz_d;

  always_comb begin
    den_d  = s2_sqx_q + s2_sqy_q;
    v_re_d = '0;
    v_im_d = '0;
    rnd_d  = 1'b0;
    div_d  = 1'b0;
    eq_d   = 1'b0;
    dz_d   = 1'b0;
    unique case (s2_act_q) inside
      cau_pkg::ACT_ADD, cau_pkg::ACT_SUB, cau_pkg::ACT_NEG, cau_pkg::ACT_CONJ: begin
        v_re_d = (PW+1)'(s2_sre_q);
        v_im_d = (PW+1)'(s2_sim_q);
      end
      cau_pkg::ACT_MUL: begin
        v_re_d = (PW+1)'(s2_prr_q) - (PW+1)'(s2_pii_q);
        v_im_d = (PW+1)'(s2_pri_q) + (PW+1)'(s2_pir_q);
        rnd_d  = 1'b1;
      end
      cau_pkg::ACT_DIV: begin
        if (s2_bz_q) begin
          dz_d = 1'b1;
        end else begin
          v_re_d = (PW+1)'(s2_prr_q) + (PW+1)'(s2_pii_q);
          v_im_d = (PW+1)'(s2_pir_q) - (PW+1)'(s2_pri_q);
          div_d  = 1'b1;
        end
      end
      cau_pkg::ACT_ABS2: begin
        v_re_d = signed'({1'b0, den_d});
        rnd_d  = 1'b1;
      end
      cau_pkg::ACT_RECIP: begin
        if (s2_az_q) begin
          dz_d = 1'b1;
        end else begin
          v_re_d = (PW+1)'(s2_ar_q) <<< F;
          v_im_d = -((PW+1)'(s2_ai_q) <<< F);
          div_d  = 1'b1;
        end
      end
      cau_pkg::ACT_EQ: begin
        eq_d = s2_eq_q;
      end
      default: begin
        v_re_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q <= 1'b0;
    end else begin
      s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s3_vre_q <= v_re_d;
    s3_vim_q <= v_im_d;
    s3_den_q <= den_d;
    s3_rnd_q <= rnd_d;
    s3_div_q <= div_d;
    s3_eq_q  <= eq_d;
    s3_dz_q  <= dz_d;
  end

  logic               s4_valid_q;
  logic               s4_nre_q, s4_nim_q;
  logic [PW-1:0]      s4_mre_q, s4_mim_q;
  logic [PW-1:0]      s4_den_q;
  logic               s4_rnd_q, s4_div_q, s4_eq_q, s4_dz_q;
  logic signed [PW:0] nre, nim;

  assign nre = -s3_vre_q;
  assign nim = -s3_vim_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_valid_q <= 1'b0;
    end else begin
      s4_valid_q <= s3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s4_nre_q <= s3_vre_q[PW];
    s4_nim_q <= s3_vim_q[PW];
    s4_mre_q <= s3_vre_q[PW] ? nre[PW-1:0] : s3_vre_q[PW-1:0];
    s4_mim_q <= s3_vim_q[PW] ? nim[PW-1:0] : s3_vim_q[PW-1:0];
    s4_den_q <= s3_den_q;
    s4_rnd_q <= s3_rnd_q;
    s4_div_q <= s3_div_q;
    s4_eq_q  <= s3_eq_q;
    s4_dz_q  <= s3_dz_q;
  end

  function automatic cau_pkg::cau_lane_t lane_init(input logic neg, input logic [PW-1:0] mag,
                                                   input logic [PW-1:0] den, input logic rnd);
    cau_pkg::cau_lane_t l;
    logic [PW:0]        sum;
    logic [PW-F:0]      r;
    logic [W:0]         pr, pm;
    sum = (PW+1)'(mag) + HALF;
    r   = sum[PW:F];
    pr  = (|r[PW-F:W+1]) ? {1'b1, W'(0)} : r[W:0];
    pm  = (|mag[PW-1:W+1]) ? {1'b1, W'(0)} : mag[W:0];
    l.neg = neg;
    l.ovf = (PW'(mag[PW-1:SH]) >= den);
    l.rem = PW'(mag[PW-1:SH]);
    l.qn  = {mag[SH-1:0], F'(0)};
    l.pre = rnd ? pr : pm;
    return l;
  endfunction

  logic valid_q;
  cau_pkg::cau_word_t word_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= s4_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q.is_div <= s4_div_q;
    word_q.eq     <= s4_eq_q;
    word_q.dz     <= s4_dz_q;
    word_q.den    <= s4_den_q;
    word_q.re     <= lane_init(s4_nre_q, s4_mre_q, s4_den_q, s4_rnd_q);
    word_q.im     <= lane_init(s4_nim_q, s4_mim_q, s4_den_q, s4_rnd_q);
  end

  assign valid_o = valid_q;
  assign word_o  = word_q;

endmodule

// ----- rtl/core/cau_cell.sv -----
// ----------------------------------------------------------------------------
// cau_cell
// One restoring division step for both lanes; yields one quotient bit per
// lane and hands the word to the next cell.
// ----------------------------------------------------------------------------
module cau_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  cau_pkg::cau_word_t word_i,
  output logic               valid_o,
  output cau_pkg::cau_word_t word_o
);

  localparam int unsigned W  = cau_pkg::W;
  localparam int unsigned PW = cau_pkg::PW;

  function automatic cau_pkg::cau_lane_t step(input cau_pkg::cau_lane_t l,
                                              input logic [PW-1:0] den);
    cau_pkg::cau_lane_t o;
    logic [PW-1:0]      t;
    logic               ge;
    t  = {l.rem[PW-2:0], l.qn[W-1]};
    ge = (t >= den);
    o      = l;
    o.rem  = ge ? (t - den) : t;
    o.qn   = {l.qn[W-2:0], ge};
    return o;
  endfunction

  logic               valid_q;
  cau_pkg::cau_word_t word_q;
  cau_pkg::cau_word_t word_d;

  always_comb begin
    word_d    = word_i;
    word_d.re = step(word_i.re, word_i.den);
    word_d.im = step(word_i.im, word_i.den);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign valid_o = valid_q;
  assign word_o  = word_q;

endmodule

// ----- rtl/core/cau_tail.sv -----
// ----------------------------------------------------------------------------
// cau_tail
// Quotient rounding, saturation and the registered result word.
// ----------------------------------------------------------------------------
module cau_tail (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         valid_i,
  input  cau_pkg::cau_word_t           word_i,
  output logic                         valid_o,
  output logic signed [cau_pkg::W-1:0] res_re_o,
  output logic signed [cau_pkg::W-1:0] res_im_o,
  output logic                         is_equal_o,
  output logic                         div_by_zero_o,
  output logic                         saturated_o
);

  localparam int unsigned W  = cau_pkg::W;
  localparam int unsigned PW = cau_pkg::PW;
  localparam logic [W:0]  LIM = (W+1)'(1) << (W - 1);

  function automatic logic [W:0] fin_mag(input cau_pkg::cau_lane_t l, input logic is_div,
                                         input logic [PW-1:0] den);
    logic rnd;
    rnd = ({l.rem, 1'b0} >= {1'b0, den});
    if (!is_div) begin
      return l.pre;
    end else if (l.ovf) begin
      return {1'b1, W'(0)};
    end
    return {1'b0, l.qn} + (W+1)'(rnd);
  endfunction

  logic          t1_valid_q;
  logic          t1_nre_q, t1_nim_q, t1_eq_q, t1_dz_q;
  logic [W:0]    t1_mre_q, t1_mim_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t1_valid_q <= 1'b0;
    end else begin
      t1_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    t1_nre_q <= word_i.re.neg;
    t1_nim_q <= word_i.im.neg;
    t1_mre_q <= fin_mag(word_i.re, word_i.is_div, word_i.den);
    t1_mim_q <= fin_mag(word_i.im, word_i.is_div, word_i.den);
    t1_eq_q  <= word_i.eq;
    t1_dz_q  <= word_i.dz;
  end

  logic         sat_re, sat_im;
  logic [W-1:0] val_re, val_im;
  logic [W:0]   neg_re, neg_im;

  assign neg_re = -t1_mre_q;
  assign neg_im = -t1_mim_q;

  always_comb begin
    if (t1_nre_q) begin
      sat_re = (t1_mre_q > LIM);
      val_re = sat_re ? LIM[W-1:0] : neg_re[W-1:0];
    end else begin
      sat_re = (t1_mre_q >= LIM);
      val_re = sat_re ? (LIM[W-1:0] - W'(1)) : t1_mre_q[W-1:0];
    end
    if (t1_nim_q) begin
      sat_im = (t1_mim_q > LIM);
      val_im = sat_im ? LIM[W-1:0] : neg_im[W-1:0];
    end else begin
      sat_im = (t1_mim_q >= LIM);
      val_im = sat_im ? (LIM[W-1:0] - W'(1)) : t1_mim_q[W-1:0];
    end
  end

  logic         valid_q;
  logic [W-1:0] res_re_q, res_im_q;
  logic         eq_q, dz_q, sat_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= t1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    res_re_q <= val_re;
    res_im_q <= val_im;
    eq_q     <= t1_eq_q;
    dz_q     <= t1_dz_q;
    sat_q    <= sat_re | sat_im;
  end

  assign valid_o       = valid_q;
  assign res_re_o      = signed'(res_re_q);
  assign res_im_o      = signed'(res_im_q);
  assign is_equal_o    = eq_q;
  assign div_by_zero_o = dz_q;
  assign saturated_o   = sat_q;

endmodule
